// ===== rtl/voxel_neighbor_occupancy_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the voxel neighbour occupancy block
// Each macro expects clk in scope; all but VNO_ASSERT_NEXT_RST also expect rst_n.
// ---------------------------------------------------------------------------
`ifndef VOXEL_NEIGHBOR_OCCUPANCY_TOP_MACROS_SVH
`define VOXEL_NEIGHBOR_OCCUPANCY_TOP_MACROS_SVH

// Same-cycle implication, masked during reset
`define VNO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vno assertion failed");

// Next-cycle implication, masked during reset
`define VNO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vno assertion failed");

// Next-cycle implication, live during reset
`define VNO_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vno assertion failed");

`endif

// ===== rtl/vno_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vno_pkg
// Types and constants shared by the voxel neighbour occupancy block.
// ---------------------------------------------------------------------------
package vno_pkg;

  localparam int DEF_SIZE_X    = 64;
  localparam int DEF_SIZE_Y    = 16;
  localparam int DEF_SIZE_Z    = 64;
  localparam int DEF_CODE_BITS = 8;

  localparam int POS_X_W  = 6;
  localparam int POS_Y_W  = 4;
  localparam int POS_Z_W  = 6;
  localparam int CODE_W   = 8;
  localparam int MASK_W   = 27;
  localparam int KIDX_W   = 5;
  // coordinate compare width, holds a size of 256 plus one
  localparam int COORD_EXT_W = 10;

  localparam logic [CODE_W-1:0] AIR_RESET = '0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // offset codes along one axis
  localparam logic [1:0] D_NEG = 2'd0;
  localparam logic [1:0] D_MID = 2'd1;
  localparam logic [1:0] D_POS = 2'd2;

  localparam logic [KIDX_W-1:0] K_LAST   = 5'd26;
  localparam logic [KIDX_W-1:0] K_CENTRE = 5'd13;
  localparam int BIT_XN = 12;
  localparam int BIT_XP = 14;
  localparam int BIT_YN = 10;
  localparam int BIT_YP = 16;
  localparam int BIT_ZN = 4;
  localparam int BIT_ZP = 22;
  localparam int BIT_CENTRE = 13;

  typedef struct packed {
    logic               operation;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic [POS_Z_W-1:0] pos_z;
    logic [CODE_W-1:0]  code_in;
  } vno_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_out;
    logic [MASK_W-1:0] neighbor_mask;
    logic              drawn;
  } vno_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } vno_state_t;

endpackage

// ===== rtl/vno_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vno_ram
// Single-port synchronous RAM, registered read, no reset on contents.
// ---------------------------------------------------------------------------
module vno_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/voxel_neighbor_occupancy_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// voxel_neighbor_occupancy_top
// Voxel code store with 3x3x3 neighbourhood occupancy and face culling.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): one beat is a write or a
// query. A write stores code_in at (pos_x, pos_y, pos_z) and returns an
// all-zero result beat in the next cycle. A query walks the 27 positions of
// the neighbourhood through the single-port voxel RAM, one read a cycle,
// and returns code, occupancy mask and drawn flag on the output channel.
// A query registers the position, reads in the scan state, covers the RAM
// read latency in the drain state and forms the result in the done state. A
// query outside the grid returns zeros in the next cycle, like a write.
// Throughput: a write every cycle while out_stall is low; a query holds
// the RAM port for its 27 reads. The block holds one item at a time.
// Output channel (out_valid / out_stall / out_data): result beat held in a
// register; while out_stall is high it holds, and in_stall stays high
// until the register can take the next result.
// Configuration (cfg_valid / cfg_ready / cfg_data): air code, always ready.
// Reset (rst_n, synchronous): clears control and air code; RAM contents
// are left as they are and must be written before they are queried.
// ---------------------------------------------------------------------------
module voxel_neighbor_occupancy_top #(
  parameter int SIZE_X    = vno_pkg::DEF_SIZE_X,
  parameter int SIZE_Y    = vno_pkg::DEF_SIZE_Y,
  parameter int SIZE_Z    = vno_pkg::DEF_SIZE_Z,
  parameter int CODE_BITS = vno_pkg::DEF_CODE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  vno_pkg::vno_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output vno_pkg::vno_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vno_pkg::CODE_W-1:0]    cfg_data
);

  import vno_pkg::*;

  localparam int DEPTH  = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int STEP_X = SIZE_Y * SIZE_Z;
  localparam int STEP_Y = SIZE_Z;
  localparam int CMP_W  = (CODE_BITS > CODE_W) ? CODE_BITS : CODE_W;

  vno_state_t state_r, state_nxt;

  logic [KIDX_W-1:0]    k_r;
  logic [1:0]           dx_r, dy_r, dz_r;
  logic [ADDR_W-1:0]    base_r;
  logic [POS_X_W-1:0]   x_r;
  logic [POS_Y_W-1:0]   y_r;
  logic [POS_Z_W-1:0]   z_r;
  logic                 pend_r;
  logic [KIDX_W-1:0]    pend_k_r;
  logic                 pend_inb_r;
  logic [MASK_W-1:0]    solid_r;
  logic [CODE_BITS-1:0] centre_r;
  logic [CODE_W-1:0]    air_r;
  logic                 out_valid_r;
  vno_out_t             out_data_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 in_grid;
  logic [ADDR_W-1:0]    in_addr;
  logic [COORD_EXT_W-1:0] nx, ny, nz;
  logic                 nb_inb;
  logic [ADDR_W-1:0]    off_x, off_y, off_z;
  logic [ADDR_W-1:0]    nb_addr;
  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_addr;
  logic [CODE_BITS-1:0] ram_rdata;
  logic                 ld_zero, ld_result;
  logic                 start_scan;
  logic                 rd_solid;
  logic                 covered;

  // input decode
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign in_grid  = (COORD_EXT_W'(in_data.pos_x) < COORD_EXT_W'(SIZE_X)) &&
                    (COORD_EXT_W'(in_data.pos_y) < COORD_EXT_W'(SIZE_Y)) &&
                    (COORD_EXT_W'(in_data.pos_z) < COORD_EXT_W'(SIZE_Z));
  assign in_addr  = ADDR_W'(in_data.pos_x) * ADDR_W'(STEP_X) +
                    ADDR_W'(in_data.pos_y) * ADDR_W'(STEP_Y) +
                    ADDR_W'(in_data.pos_z);

  // neighbour position, offset codes carry a bias of one
  assign nx = COORD_EXT_W'(x_r) + COORD_EXT_W'(dx_r);
  assign ny = COORD_EXT_W'(y_r) + COORD_EXT_W'(dy_r);
  assign nz = COORD_EXT_W'(z_r) + COORD_EXT_W'(dz_r);
  assign nb_inb = (nx != '0) && (nx <= COORD_EXT_W'(SIZE_X)) &&
                  (ny != '0) && (ny <= COORD_EXT_W'(SIZE_Y)) &&
                  (nz != '0) && (nz <= COORD_EXT_W'(SIZE_Z));

  always_comb begin
    off_x = '0;
    off_y = '0;
    off_z = '0;
    if (dx_r == D_NEG) begin
      off_x = ADDR_W'(0) - ADDR_W'(STEP_X);
    end else if (dx_r == D_POS) begin
      off_x = ADDR_W'(STEP_X);
    end
    if (dy_r == D_NEG) begin
      off_y = ADDR_W'(0) - ADDR_W'(STEP_Y);
    end else if (dy_r == D_POS) begin
      off_y = ADDR_W'(STEP_Y);
    end
    if (dz_r == D_NEG) begin
      off_z = ADDR_W'(0) - ADDR_W'(1);
    end else if (dz_r == D_POS) begin
      off_z = ADDR_W'(1);
    end
  end

  assign nb_addr = base_r + off_x + off_y + off_z;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_scan) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (k_r == K_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = in_addr;
    ld_zero    = 1'b0;
    ld_result  = 1'b0;
    start_scan = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        start_scan = in_acc && (in_data.operation == OP_QUERY) && in_grid;
        ram_we     = in_acc && (in_data.operation == OP_WRITE) && in_grid;
        ld_zero    = in_acc && !start_scan;
      end
      ST_SCAN: begin
        ram_re   = nb_inb;
        ram_addr = nb_addr;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        ld_result = out_free;
      end
      default: begin
      end
    endcase
  end

  vno_ram #(
    .WIDTH (CODE_BITS),
    .DEPTH (DEPTH)
  ) u_vno_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (CODE_BITS'(in_data.code_in)),
    .rdata (ram_rdata)
  );

  assign rd_solid = pend_inb_r && (CMP_W'(ram_rdata) != CMP_W'(air_r));
  assign covered  = solid_r[BIT_XN] && solid_r[BIT_XP] && solid_r[BIT_YN] &&
                    solid_r[BIT_YP] && solid_r[BIT_ZN] && solid_r[BIT_ZP];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      air_r       <= AIR_RESET;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == ST_SCAN);
      if (ld_zero || ld_result) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        air_r <= cfg_data;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (start_scan) begin
      k_r    <= '0;
      dx_r   <= D_NEG;
      dy_r   <= D_NEG;
      dz_r   <= D_NEG;
      base_r <= in_addr;
      x_r    <= in_data.pos_x;
      y_r    <= in_data.pos_y;
      z_r    <= in_data.pos_z;
    end else if (state_r == ST_SCAN) begin
      k_r <= k_r + KIDX_W'(1);
      if (dx_r == D_POS) begin
        dx_r <= D_NEG;
        if (dy_r == D_POS) begin
          dy_r <= D_NEG;
          dz_r <= dz_r + 2'd1;
        end else begin
          dy_r <= dy_r + 2'd1;
        end
      end else begin
        dx_r <= dx_r + 2'd1;
      end
    end
    pend_k_r   <= k_r;
    pend_inb_r <= nb_inb;
    if (pend_r) begin
      solid_r[pend_k_r] <= rd_solid;
      if (pend_k_r == K_CENTRE) begin
        centre_r <= ram_rdata;
      end
    end
    if (ld_zero) begin
      out_data_r <= '0;
    end else if (ld_result) begin
      out_data_r.code_out      <= CODE_W'(centre_r);
      out_data_r.neighbor_mask <= solid_r & ~(MASK_W'(1) << BIT_CENTRE);
      out_data_r.drawn         <= solid_r[BIT_CENTRE] && !covered;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

// ===== rtl/vno_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vno_checker
// Port-level checks on the voxel neighbour occupancy block, bound to top.
// ---------------------------------------------------------------------------
`include "voxel_neighbor_occupancy_top_macros.svh"

module vno_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input vno_pkg::vno_in_t              in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input vno_pkg::vno_out_t             out_data
);

  import vno_pkg::*;

  // held result beat stays put
  `VNO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // reset empties the result register
  `VNO_ASSERT_NEXT_RST(a_rst_clear, !rst_n, !out_valid)

  // a write gives an all-zero result in the next cycle
  `VNO_ASSERT_NEXT(a_write_zero, in_valid && !in_stall && (in_data.operation == OP_WRITE), out_valid && (out_data == '0))

  // a drawn voxel never has all six faces covered
  `VNO_ASSERT_NOW(a_drawn_face, out_valid && out_data.drawn, !(out_data.neighbor_mask[BIT_XN] && out_data.neighbor_mask[BIT_XP] && out_data.neighbor_mask[BIT_YN] && out_data.neighbor_mask[BIT_YP] && out_data.neighbor_mask[BIT_ZN] && out_data.neighbor_mask[BIT_ZP]))

endmodule

bind voxel_neighbor_occupancy_top vno_checker u_vno_checker (.*);
